FILE: src/sphav_pkg.sv
// Shared types and codes for the pair artificial-viscosity pipeline.
`timescale 1ns / 1ps
package sphav_pkg;

    localparam logic [1:0] KIND_SKIP = 2'd0;
    localparam logic [1:0] KIND_I    = 2'd1;
    localparam logic [1:0] KIND_IJ   = 2'd2;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_BETA  = 2'd1;
    localparam logic [1:0] REG_ETA   = 2'd2;
    localparam logic [1:0] REG_C     = 2'd3;

    typedef struct packed {
        logic [1:0]         pair_kind;
        logic [31:0]        h_sum;
        logic [31:0]        rho_sum;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic signed [31:0] sep_x;
        logic signed [31:0] sep_y;
        logic [31:0]        dist_sq;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic [31:0]        mass_i;
        logic [31:0]        mass_j;
    } pair_in_t;

    typedef struct packed {
        logic signed [31:0] force_i_x;
        logic signed [31:0] force_i_y;
        logic signed [31:0] force_j_x;
        logic signed [31:0] force_j_y;
        logic               apply_i;
        logic               apply_j;
    } pair_out_t;

    // Saturate a wide signed value to signed 32 bit
    function automatic logic signed [31:0] sat32(input logic signed [127:0] x);
        logic signed [31:0] r;
        if (x > 128'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -128'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

FILE: src/sph_artificial_viscosity_pair.sv
// Top level of the pair artificial-viscosity pipeline.
// A pair request is taken on every cycle that start is high (busy is always low), and its result
// appears on result with done high after 13 stages of multiply/saturate logic plus two
// pipelined restoring dividers of 67 and 51 stages (mu and the density division; the latter is
// FRAC_BITS + 35 stages). One pair per clock is sustained; results cannot be held off.
`timescale 1ns / 1ps
module sph_artificial_viscosity_pair #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sphav_pkg::pair_in_t   request,
    output logic                  done,
    output sphav_pkg::pair_out_t  result,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    localparam int MUW = 64 + 2;            // mu numerator width (h*d, signed)
    localparam int AFW = 32 + FRAC_BITS + 2; // force numerator width
    localparam int DENW = 65 - FRAC_BITS;    // mu denominator width (dsq + eh^2)

    // side info carried through the dividers
    typedef struct packed {
        logic [1:0]         kind;
        logic               neg;
        logic [31:0]        rho;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic [31:0]        mi;
        logic [31:0]        mj;
    } side_t;
    localparam int SIDEW = $bits(side_t);

    typedef struct packed {
        logic [1:0]         kind;
        logic               neg;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic [31:0]        mi;
        logic [31:0]        mj;
    } side2_t;
    localparam int SIDE2W = $bits(side2_t);

    // configuration
    logic [31:0] alpha_reg, beta_reg, eta_reg, c_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 32'd65536;
            beta_reg  <= 32'd131072;
            eta_reg   <= 32'd6554;
            c_reg     <= 32'd655360;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sphav_pkg::REG_ALPHA: alpha_reg <= cfg_data;
                sphav_pkg::REG_BETA:  beta_reg  <= cfg_data;
                sphav_pkg::REG_ETA:   eta_reg   <= cfg_data;
                sphav_pkg::REG_C:     c_reg     <= cfg_data;
                default:              alpha_reg <= alpha_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // alpha*c, recomputed continuously (config must be static while items run; not enforced here)
    logic [63:0] ac_prod_reg;
    logic [31:0] ac_reg;
    always_ff @(posedge clk)
    begin
        ac_prod_reg <= 64'(alpha_reg) * 64'(c_reg);
        ac_reg      <= ((ac_prod_reg >> FRAC_BITS) > 64'hffffffff) ? 32'hffffffff
                       : 32'(ac_prod_reg >> FRAC_BITS);
    end

    // stage 1: products of velocity and separation, eta*h
    logic               v1_reg;
    logic signed [63:0] p1_reg, p2_reg;
    logic [63:0]        eh_prod_reg;
    logic [31:0]        h1_reg, dsq1_reg;
    sphav_pkg::pair_in_t in1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        p1_reg      <= 64'(request.rel_vel_x) * 64'(request.sep_x);
        p2_reg      <= 64'(request.rel_vel_y) * 64'(request.sep_y);
        eh_prod_reg <= 64'(eta_reg) * 64'({1'b0, request.h_sum[31:1]});
        h1_reg      <= {1'b0, request.h_sum[31:1]};
        dsq1_reg    <= request.dist_sq;
        in1_reg     <= request;
    end

    // stage 2: dot product sum (exact, then floor shift), eta*h saturate
    logic               v2_reg;
    logic signed [31:0] d2_reg;
    logic               neg2_reg;
    logic [31:0]        eh2_reg, h2_reg, dsq2_reg;
    sphav_pkg::pair_in_t in2_reg;
    logic signed [64:0] dot_full;
    logic signed [64:0] dot_sh;
    assign dot_full = 65'(p1_reg) + 65'(p2_reg);
    assign dot_sh   = dot_full >>> FRAC_BITS;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        d2_reg   <= sphav_pkg::sat32(128'(dot_sh));
        neg2_reg <= dot_sh[64];
        eh2_reg  <= ((eh_prod_reg >> FRAC_BITS) > 64'hffffffff) ? 32'hffffffff
                    : 32'(eh_prod_reg >> FRAC_BITS);
        h2_reg   <= h1_reg;
        dsq2_reg <= dsq1_reg;
        in2_reg  <= in1_reg;
    end

    // stage 3: eh^2 and h*d
    logic               v3_reg;
    logic [63:0]        ehsq3_reg;
    logic signed [63:0] hd3_reg;
    logic [31:0]        dsq3_reg;
    logic               neg3_reg;
    sphav_pkg::pair_in_t in3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else        v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        ehsq3_reg <= 64'(eh2_reg) * 64'(eh2_reg);
        hd3_reg   <= $signed({32'd0, h2_reg}) * 64'(d2_reg);
        dsq3_reg  <= dsq2_reg;
        neg3_reg  <= neg2_reg;
        in3_reg   <= in2_reg;
    end

    // stage 4: denominator; eh^2 alone can reach 64 - FRAC_BITS bits
    logic [DENW-1:0] den_full;
    assign den_full = DENW'(dsq3_reg) + DENW'(ehsq3_reg >> FRAC_BITS);

    side_t side4;
    assign side4 = '{kind: in3_reg.pair_kind, neg: neg3_reg, rho: {1'b0, in3_reg.rho_sum[31:1]},
                     gx: in3_reg.grad_x, gy: in3_reg.grad_y,
                     mi: in3_reg.mass_i, mj: in3_reg.mass_j};

    logic                  mu_v;
    logic signed [MUW-1:0] mu_q;
    logic                  mu_dz;
    logic [SIDEW-1:0]      mu_side_raw;
    side_t                 mu_side;
    logic [MUW-1:0]        mu_num;
    logic [DENW-1:0]       mu_den;
    assign mu_num = MUW'(hd3_reg);
    assign mu_den = den_full;

    sphav_div #(.NW(MUW), .DW(DENW), .SW(SIDEW)) u_mu_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3_reg),
        .num      (mu_num),
        .den      (mu_den),
        .side_in  (side4),
        .out_valid(mu_v),
        .quot     (mu_q),
        .den_zero (mu_dz),
        .side_out (mu_side_raw)
    );
    assign mu_side = side_t'(mu_side_raw);

    // stage M1: saturate mu
    logic               m1v_reg;
    logic signed [31:0] mu1_reg;
    side_t              s1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m1v_reg <= 1'b0;
        else        m1v_reg <= mu_v;
    end
    always_ff @(posedge clk)
    begin
        if (mu_dz)
            mu1_reg <= (mu_q < 0) ? 32'sh80000000 : ((mu_q > 0) ? 32'sh7fffffff : 32'sd0);
        else
            mu1_reg <= sphav_pkg::sat32(128'(mu_q));
        s1_reg <= mu_side;
    end
    // dividing by zero: the divider returns an extreme value carrying the numerator's sign,
    // or zero for a zero numerator

    // stage M2: mu^2 and ac*mu
    logic               m2v_reg;
    logic [63:0]        musq2_reg;
    logic signed [63:0] acmu2_reg;
    side_t              s2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m2v_reg <= 1'b0;
        else        m2v_reg <= m1v_reg;
    end
    always_ff @(posedge clk)
    begin
        musq2_reg <= 64'(64'(mu1_reg) * 64'(mu1_reg));
        acmu2_reg <= $signed({32'd0, ac_reg}) * 64'(mu1_reg);
        s2_reg    <= s1_reg;
    end

    // stage M3: saturate mu2 and t2
    logic               m3v_reg;
    logic [31:0]        mu23_reg;
    logic signed [31:0] t23_reg;
    side_t              s3_reg;
    logic [63:0]        musq_sh;
    assign musq_sh = musq2_reg >> FRAC_BITS;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m3v_reg <= 1'b0;
        else        m3v_reg <= m2v_reg;
    end
    always_ff @(posedge clk)
    begin
        mu23_reg <= (musq_sh > 64'h7fffffff) ? 32'h7fffffff : musq_sh[31:0];
        t23_reg  <= sphav_pkg::sat32(128'(acmu2_reg >>> FRAC_BITS));
        s3_reg   <= s2_reg;
    end

    // stage M4: beta*mu2
    logic               m4v_reg;
    logic [63:0]        bm4_reg;
    logic signed [31:0] t24_reg;
    side_t              s4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m4v_reg <= 1'b0;
        else        m4v_reg <= m3v_reg;
    end
    always_ff @(posedge clk)
    begin
        bm4_reg <= 64'(beta_reg) * 64'(mu23_reg);
        t24_reg <= t23_reg;
        s4_reg  <= s3_reg;
    end

    // stage M5: numerator t1 - t2 (difference needs 33 bits before saturation)
    logic               m5v_reg;
    logic signed [31:0] num5_reg;
    side_t              s5_reg;
    logic [63:0]        bm_sh;
    logic signed [32:0] t1;
    assign bm_sh = bm4_reg >> FRAC_BITS;
    assign t1    = (bm_sh > 64'h7fffffff) ? 33'sh07fffffff : $signed({1'b0, bm_sh[31:0]});
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m5v_reg <= 1'b0;
        else        m5v_reg <= m4v_reg;
    end
    always_ff @(posedge clk)
    begin
        num5_reg <= sphav_pkg::sat32(128'(t1) - 128'(t24_reg));
        s5_reg   <= s4_reg;
    end

    // density divider
    side2_t side5;
    assign side5 = '{kind: s5_reg.kind, neg: s5_reg.neg, gx: s5_reg.gx, gy: s5_reg.gy,
                     mi: s5_reg.mi, mj: s5_reg.mj};
    logic [AFW-1:0] af_num;
    assign af_num = AFW'($signed(num5_reg)) <<< FRAC_BITS;

    logic                  af_v, af_dz;
    logic signed [AFW-1:0] af_q;
    logic [SIDE2W-1:0]     af_side_raw;
    side2_t                af_side;
    sphav_div #(.NW(AFW), .DW(32), .SW(SIDE2W)) u_rho_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m5v_reg),
        .num      (af_num),
        .den      (s5_reg.rho),
        .side_in  (side5),
        .out_valid(af_v),
        .quot     (af_q),
        .den_zero (af_dz),
        .side_out (af_side_raw)
    );
    assign af_side = side2_t'(af_side_raw);

    // stage F1: force term, zeroed for non-negative dot or skipped kinds
    logic               f1v_reg;
    logic signed [31:0] avf1_reg;
    side2_t             f1s_reg;
    logic               ai_f;
    assign ai_f = (af_side.kind == sphav_pkg::KIND_I) || (af_side.kind == sphav_pkg::KIND_IJ);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) f1v_reg <= 1'b0;
        else        f1v_reg <= af_v;
    end
    always_ff @(posedge clk)
    begin
        if (!ai_f || !af_side.neg)
            avf1_reg <= 32'sd0;
        else if (af_dz)
            avf1_reg <= (af_q > 0) ? 32'sh7fffffff : ((af_q < 0) ? 32'sh80000000 : 32'sd0);
        else
            avf1_reg <= sphav_pkg::sat32(128'(af_q));
        f1s_reg <= af_side;
    end

    // stage F2: force times gradient
    logic               f2v_reg;
    logic signed [63:0] wx2_reg, wy2_reg;
    side2_t             f2s_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) f2v_reg <= 1'b0;
        else        f2v_reg <= f1v_reg;
    end
    always_ff @(posedge clk)
    begin
        wx2_reg <= 64'(avf1_reg) * 64'(f1s_reg.gx);
        wy2_reg <= 64'(avf1_reg) * 64'(f1s_reg.gy);
        f2s_reg <= f1s_reg;
    end

    // stage F3: saturate w
    logic               f3v_reg;
    logic signed [31:0] wx3_reg, wy3_reg;
    side2_t             f3s_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) f3v_reg <= 1'b0;
        else        f3v_reg <= f2v_reg;
    end
    always_ff @(posedge clk)
    begin
        wx3_reg <= sphav_pkg::sat32(128'(wx2_reg >>> FRAC_BITS));
        wy3_reg <= sphav_pkg::sat32(128'(wy2_reg >>> FRAC_BITS));
        f3s_reg <= f2s_reg;
    end

    // stage F4: mass products
    logic               f4v_reg;
    logic signed [64:0] ix4_reg, iy4_reg, jx4_reg, jy4_reg;
    side2_t             f4s_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) f4v_reg <= 1'b0;
        else        f4v_reg <= f3v_reg;
    end
    always_ff @(posedge clk)
    begin
        ix4_reg <= $signed({33'd0, f3s_reg.mj}) * 65'(wx3_reg);
        iy4_reg <= $signed({33'd0, f3s_reg.mj}) * 65'(wy3_reg);
        jx4_reg <= $signed({33'd0, f3s_reg.mi}) * 65'(wx3_reg);
        jy4_reg <= $signed({33'd0, f3s_reg.mi}) * 65'(wy3_reg);
        f4s_reg <= f3s_reg;
    end

    // stage F5: shift, negate, saturate; output register
    logic      done_reg;
    sphav_pkg::pair_out_t result_reg;
    logic      aj_f;
    assign aj_f = (f4s_reg.kind == sphav_pkg::KIND_IJ);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= f4v_reg;
    end
    always_ff @(posedge clk)
    begin
        result_reg.force_i_x <= sphav_pkg::sat32(-128'(ix4_reg >>> FRAC_BITS));
        result_reg.force_i_y <= sphav_pkg::sat32(-128'(iy4_reg >>> FRAC_BITS));
        result_reg.force_j_x <= aj_f ? sphav_pkg::sat32(128'(jx4_reg >>> FRAC_BITS)) : 32'sd0;
        result_reg.force_j_y <= aj_f ? sphav_pkg::sat32(128'(jy4_reg >>> FRAC_BITS)) : 32'sd0;
        result_reg.apply_i   <= (f4s_reg.kind == sphav_pkg::KIND_I) || aj_f;
        result_reg.apply_j   <= aj_f;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_j_only_with_i: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!result.apply_j || result.apply_i))
        else $error("apply_j without apply_i");
    a_j_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.apply_j |-> (result.force_j_x == 0 && result.force_j_y == 0))
        else $error("j force without kind 2");
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.apply_i |-> (result.force_i_x == 0 && result.force_i_y == 0))
        else $error("i force on skipped pair");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
endmodule

FILE: src/sphav_div.sv
// Pipelined restoring divider: signed numerator over unsigned divisor, one bit per stage.
`timescale 1ns / 1ps
module sphav_div #(
    parameter int NW = 96,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    input  logic [SW-1:0]        side_in,
    output logic                 out_valid,
    output logic signed [NW-1:0] quot,
    output logic                 den_zero,
    output logic [SW-1:0]        side_out
);
    // per-stage registers: partial remainder, quotient bits, divisor
    logic           valid_reg [NW+1];
    logic [NW-1:0]  q_reg    [NW+1];
    logic [DW:0]    r_reg    [NW+1];
    logic [DW-1:0]  d_reg    [NW+1];
    logic           neg_reg  [NW+1];
    logic           nz_reg   [NW+1];
    logic [SW-1:0]  side_reg [NW+1];
    logic signed [NW-1:0] q_div;

    // load stage: take magnitude of numerator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0]    <= num[NW-1] ? NW'(-num) : NW'(num);
        r_reg[0]    <= '0;
        d_reg[0]    <= den;
        neg_reg[0]  <= num[NW-1];
        nz_reg[0]   <= (num != '0);
        side_reg[0] <= side_in;
    end

    // one quotient bit per stage
    for (genvar s = 0; s < NW; s++)
    begin : g_stage
        logic [DW+1:0] trial;
        logic [DW:0]   shifted;
        assign shifted = {r_reg[s][DW-1:0], q_reg[s][NW-1]};
        assign trial   = {1'b0, shifted} - {2'b00, d_reg[s]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!trial[DW+1])
            begin
                r_reg[s+1] <= trial[DW:0];
                q_reg[s+1] <= {q_reg[s][NW-2:0], 1'b1};
            end
            else
            begin
                r_reg[s+1] <= shifted;
                q_reg[s+1] <= {q_reg[s][NW-2:0], 1'b0};
            end
            d_reg[s+1]    <= d_reg[s];
            neg_reg[s+1]  <= neg_reg[s];
            nz_reg[s+1]   <= nz_reg[s];
            side_reg[s+1] <= side_reg[s];
        end
    end

    // zero divisor: extreme value with the numerator's sign, zero for a zero numerator
    assign q_div     = neg_reg[NW] ? -$signed(q_reg[NW]) : $signed(q_reg[NW]);
    assign out_valid = valid_reg[NW];
    assign den_zero  = (d_reg[NW] == '0);
    assign quot      = !den_zero ? q_div
                       : (!nz_reg[NW] ? '0
                          : (neg_reg[NW] ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}}));
    assign side_out  = side_reg[NW];
endmodule
